/* hdl/bgcd_pkg.sv */
// ----------------------------------------------------------------------------
// Binary GCD package
// Shared types for the controller and datapath of the binary GCD unit.
// ----------------------------------------------------------------------------
package bgcd_pkg;

	// Width of the operand and result ports.
	localparam int unsigned DATA_W = 64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // Capture new operands.
		logic strip;    // Remove one common factor of two.
		logic step;     // One reduction step.
		logic capture;  // Write the result into the output register.
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_op;   // One of the operands of this transaction was zero.
		logic both_even; // Both working operands are even.
		logic a_zero;    // The first working operand has reached zero.
	} status_t;

endpackage

/* hdl/bgcd_dp.sv */
// ----------------------------------------------------------------------------
// Binary GCD datapath
// Operand registers, common-power counter, one halve or subtract-and-halve
// step per cycle, and the registered result.
// ----------------------------------------------------------------------------
module bgcd_dp #(
	parameter int unsigned WIDTH = 64
) (
	input  logic                            clk,
	input  logic [bgcd_pkg::DATA_W-1:0]     operand_a,
	input  logic [bgcd_pkg::DATA_W-1:0]     operand_b,
	input  bgcd_pkg::cmd_t                  cmd,
	output bgcd_pkg::status_t               status,
	output logic [bgcd_pkg::DATA_W-1:0]     gcd_value,
	output logic                            zero_operand
);

	localparam int unsigned SHW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [SHW-1:0]   shift_q;
	logic             zero_q;
	logic [bgcd_pkg::DATA_W-1:0] gcd_q;
	logic             zflag_q;

	logic [WIDTH-1:0] a_in;
	logic [WIDTH-1:0] b_in;
	logic [WIDTH:0]   diff_ab;
	logic [WIDTH-1:0] diff_ba;
	logic [WIDTH-1:0] shifted;

	// Only the low WIDTH bits of each operand take part.
	assign a_in = operand_a[WIDTH-1:0];
	assign b_in = operand_b[WIDTH-1:0];

	// The borrow of a - b tells which odd operand is larger.
	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = b_q - a_q;
	assign shifted = b_q << shift_q;

	// Operand and counter registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= a_in;
			b_q     <= b_in;
			shift_q <= '0;
			zero_q  <= (a_in == '0) || (b_in == '0);
		end else if (cmd.strip) begin
			a_q     <= a_q >> 1;
			b_q     <= b_q >> 1;
			shift_q <= SHW'(shift_q + 1'b1);
		end else if (cmd.step) begin
			if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (!diff_ab[WIDTH]) begin
				a_q <= {1'b0, diff_ab[WIDTH-1:1]};
			end else begin
				b_q <= {1'b0, diff_ba[WIDTH-1:1]};
			end
		end
	end

	// Output register: remaining operand times the common power of two, or zero.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gcd_q   <= zero_q ? '0 : bgcd_pkg::DATA_W'(shifted);
			zflag_q <= zero_q;
		end
	end

	assign status.zero_op   = zero_q;
	assign status.both_even = !a_q[0] && !b_q[0];
	assign status.a_zero    = (a_q == '0);

	assign gcd_value    = gcd_q;
	assign zero_operand = zflag_q;

endmodule

/* hdl/bgcd_ctrl.sv */
// ----------------------------------------------------------------------------
// Binary GCD controller
// Sequences load, strip, reduce and capture, and owns both handshakes.
// ----------------------------------------------------------------------------
module bgcd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  bgcd_pkg::status_t    status,
	output bgcd_pkg::cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STRIP,
		ST_REDUCE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	// The output register is free when empty or when its transaction leaves now.
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);

	// Datapath commands follow from the state and the status.
	always_comb begin
		cmd.load    = accept;
		cmd.strip   = (state_q == ST_STRIP) && !status.zero_op && status.both_even;
		cmd.step    = (state_q == ST_REDUCE) && !status.a_zero;
		cmd.capture = (state_q == ST_FINISH) && slot_free;
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_STRIP;
					end
				end
				ST_STRIP: begin
					if (status.zero_op) begin
						state_q <= ST_FINISH;
					end else if (!status.both_even) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (status.a_zero) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/binary_gcd.sv */
// ----------------------------------------------------------------------------
// Binary GCD
// Greatest common divisor of two unsigned operands by the binary method.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   operand_a, operand_b
//   output    out_valid / out_stall gcd_value, zero_operand
//
// One transaction is worked at a time; a new one is taken as soon as the
// previous result sits in the output register, even while that result stalls.
// After the load, the block strips each common factor of two, then runs
// reduction steps until the first operand is zero, and then captures the
// result; each reduction step compares by the borrow of a - b.
// An operand that is zero in its low WIDTH bits skips the reduction and gives
// a flagged zero result. Reset is asynchronous and empties the block.
// ----------------------------------------------------------------------------
module binary_gcd #(
	parameter int unsigned WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bgcd_pkg::DATA_W-1:0]     operand_a,
	input  logic [bgcd_pkg::DATA_W-1:0]     operand_b,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bgcd_pkg::DATA_W-1:0]     gcd_value,
	output logic                            zero_operand
);

	bgcd_pkg::cmd_t    cmd;
	bgcd_pkg::status_t status;

	// Sequencer.
	bgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Operand registers and arithmetic.
	bgcd_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk          (clk),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.cmd          (cmd),
		.status       (status),
		.gcd_value    (gcd_value),
		.zero_operand (zero_operand)
	);

	// A flagged result carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_operand |-> gcd_value == '0)
		else $error("flagged result with nonzero value");

	// An unflagged result is never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_operand |-> gcd_value != '0)
		else $error("unflagged result is zero");

	// A new result appears only after the block was busy with a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a transaction in progress");

	// Capture never overwrites a result that is still stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !out_valid || !out_stall)
		else $error("output register overwritten while stalled");

endmodule
